@@ rtl/ibt_pkg.sv @@
// Shared types and constants for the interval booking table.
// No dependencies; every other file in rtl/ imports this package.
package ibt_pkg;

    localparam int ENTRIES_DEF   = 64;
    localparam int TIME_BITS_DEF = 32;
    localparam int IN_W          = 32;
    localparam int USED_W        = 7;

    typedef enum logic [1:0] {
        ST_BOOKED  = 2'd0,
        ST_OVERLAP = 2'd1,
        ST_FULL    = 2'd2,
        ST_INVALID = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

endpackage

@@ rtl/ibt_if.sv @@
// Request and response channel interfaces for the interval booking table.
// Depends on ibt_pkg for field widths and the status type.
interface ibt_req_if;
    import ibt_pkg::*;
    logic            valid;
    logic            ready;
    logic [IN_W-1:0] start_time;
    logic [IN_W-1:0] end_time;
    modport source (output valid, output start_time, output end_time, input ready);
    modport sink   (input valid, input start_time, input end_time, output ready);
endinterface

interface ibt_rsp_if;
    import ibt_pkg::*;
    logic              valid;
    logic              ready;
    t_status           status;
    logic [USED_W-1:0] entries_used;
    modport source (output valid, output status, output entries_used, input ready);
    modport sink   (input valid, input status, input entries_used, output ready);
endinterface

@@ rtl/ibt_slot_mem.sv @@
// Slot storage: one synchronous RAM holding {start, end} per slot.
// One write port, one read port, read data registered. Uses ibt_pkg.
module ibt_slot_mem #(
    parameter int DEPTH = ibt_pkg::ENTRIES_DEF,
    parameter int AW    = 6,
    parameter int DW    = 2 * ibt_pkg::TIME_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);
    import ibt_pkg::*;

    logic [DW-1:0] r_slot [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_slot[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_slot[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/ibt_scan_ctrl.sv @@
// Request sequencer: takes a request, scans stored slots one read per cycle,
// decides the status, appends on success and holds the response register.
// Uses ibt_pkg and the ibt_req_if / ibt_rsp_if interfaces.
module ibt_scan_ctrl #(
    parameter int ENTRIES   = ibt_pkg::ENTRIES_DEF,
    parameter int TIME_BITS = ibt_pkg::TIME_BITS_DEF,
    parameter int AW        = 6,
    parameter int CNT_W     = 7
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    ibt_req_if.sink                  i_req,
    ibt_rsp_if.source                o_rsp,
    output logic                     o_wr_en,
    output logic [AW-1:0]            o_wr_addr,
    output logic [2*TIME_BITS-1:0]   o_wr_data,
    output logic                     o_rd_en,
    output logic [AW-1:0]            o_rd_addr,
    input  logic [2*TIME_BITS-1:0]   i_rd_data
);
    import ibt_pkg::*;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

    t_state                r_state, n_state;
    logic [TIME_BITS-1:0]  r_s, r_e;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      r_rd_idx;
    logic                  r_pend;
    logic                  r_hit;
    logic                  r_invalid;
    logic                  r_out_valid;
    t_status               r_out_status;
    logic [USED_W-1:0]     r_out_used;

    logic [TIME_BITS+IN_W-1:0] in_s_ext, in_e_ext;
    logic [TIME_BITS-1:0]      in_s, in_e;
    logic [TIME_BITS-1:0]      rd_start, rd_end;
    logic                      accept, hit_now, scan_end, out_free, finish;
    t_status                   fin_status;
    logic [CNT_W-1:0]          fin_count;
    logic [CNT_W+USED_W-1:0]   fin_count_ext;

    // inputs truncated or zero-extended to the time width
    assign in_s_ext = {{TIME_BITS{1'b0}}, i_req.start_time};
    assign in_e_ext = {{TIME_BITS{1'b0}}, i_req.end_time};
    assign in_s     = in_s_ext[TIME_BITS-1:0];
    assign in_e     = in_e_ext[TIME_BITS-1:0];

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && (r_state == S_IDLE);

    assign o_rd_en   = (r_state == S_SCAN) && (r_rd_idx != r_count);
    assign o_rd_addr = r_rd_idx[AW-1:0];
    assign rd_start  = i_rd_data[2*TIME_BITS-1:TIME_BITS];
    assign rd_end    = i_rd_data[TIME_BITS-1:0];
    assign hit_now   = r_pend && (r_s < rd_end) && (rd_start < r_e);
    assign scan_end  = (r_state == S_SCAN) && (r_rd_idx == r_count) && !r_pend;

    assign out_free = !r_out_valid || o_rsp.ready;
    assign finish   = (r_state == S_DONE) && out_free;

    always_comb begin
        if (r_invalid) begin
            fin_status = ST_INVALID;
        end else if (r_hit) begin
            fin_status = ST_OVERLAP;
        end else if (r_count == FULL_CNT) begin
            fin_status = ST_FULL;
        end else begin
            fin_status = ST_BOOKED;
        end
    end

    assign o_wr_en   = finish && (fin_status == ST_BOOKED);
    assign o_wr_addr = r_count[AW-1:0];
    assign o_wr_data = {r_s, r_e};
    assign fin_count = o_wr_en ? CNT_W'(r_count + 1'b1) : r_count;
    assign fin_count_ext = {{USED_W{1'b0}}, fin_count};

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (in_s >= in_e) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_pend      <= 1'b0;
            r_hit       <= 1'b0;
            r_invalid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_rd_idx  <= '0;
                r_pend    <= 1'b0;
                r_hit     <= 1'b0;
                r_invalid <= (in_s >= in_e);
            end else begin
                // read issued this cycle compares next cycle
                r_pend <= o_rd_en;
                if (o_rd_en) begin
                    r_rd_idx <= CNT_W'(r_rd_idx + 1'b1);
                end
                if (hit_now) begin
                    r_hit <= 1'b1;
                end
            end
            if (finish) begin
                r_count     <= fin_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s <= in_s;
            r_e <= in_e;
        end
        if (finish) begin
            r_out_status <= fin_status;
            r_out_used   <= fin_count_ext[USED_W-1:0];
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.entries_used = r_out_used;

endmodule

@@ rtl/interval_booking_table.sv @@
// Interval booking table: reserves non-overlapping half-open intervals.
// Request channel i_req carries start_time and end_time; response channel
// o_rsp carries status (booked, overlap, full, empty/reversed) and the
// number of stored intervals after the transaction. Both use valid/ready.
// One request is processed at a time. A request is taken in idle, then the
// sequencer reads the stored slots from the slot RAM, one read per cycle,
// comparing each against the request in the cycle after its read. The
// block is ready again the cycle after the response is registered; it
// takes no new request until the last one has finished its scan. A booked
// interval is written to the next free slot in the same cycle its
// response is registered. The response register lets the block take and
// scan the next request while a response waits; if the receiver still
// stalls when the next response is ready, the sequencer holds it and
// accepts nothing more. Synchronous active-low reset empties the table
// (count to zero) and drops any pending response; slot RAM contents need
// no clearing, since only slots below the count are ever read.
module interval_booking_table #(
    parameter int ENTRIES   = ibt_pkg::ENTRIES_DEF,
    parameter int TIME_BITS = ibt_pkg::TIME_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ibt_req_if.sink   i_req,
    ibt_rsp_if.source o_rsp
);
    import ibt_pkg::*;

    localparam int AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int DW    = 2 * TIME_BITS;

    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [DW-1:0] wr_data, rd_data;

    ibt_scan_ctrl #(
        .ENTRIES   (ENTRIES),
        .TIME_BITS (TIME_BITS),
        .AW        (AW),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data)
    );

    ibt_slot_mem #(
        .DEPTH (ENTRIES),
        .AW    (AW),
        .DW    (DW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule
